/* rtl/hsq_pkg.sv */
// ----------------------------------------------------------------------------
// hsq_pkg
// Shared widths, register indexes, reset values and status bit positions
// for the hall sensor qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package hsq_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int COUNT_BITS_DEFAULT  = 16;

   localparam int THRESH_BITS    = 10;
   localparam int TICKS_BITS     = 16;
   localparam int ALPHA_BITS     = 16;
   localparam int EVENT_BITS     = 8;
   localparam int STATUS_BITS    = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_THRESHOLD  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OPEN_LOAD      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORT          = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT         = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FILTER_ALPHA   = 3'd6;

   localparam logic [THRESH_BITS-1:0] LOW_THRESHOLD_RESET  = 10'd300;
   localparam logic [THRESH_BITS-1:0] HIGH_THRESHOLD_RESET = 10'd400;
   localparam logic [THRESH_BITS-1:0] OPEN_LOAD_RESET      = 10'd600;
   localparam logic [THRESH_BITS-1:0] SHORT_RESET          = 10'd100;
   localparam logic [TICKS_BITS-1:0]  DEBOUNCE_RESET       = 16'd100;
   localparam logic                   INVERT_RESET         = 1'b1;
   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET          = 16'd1966;

   localparam int ST_ACTIVE = 0;
   localparam int ST_READY  = 1;
   localparam int ST_ERROR  = 2;

   typedef struct packed {
      logic [THRESH_BITS-1:0] low_threshold;
      logic [THRESH_BITS-1:0] high_threshold;
      logic [THRESH_BITS-1:0] open_load_limit;
      logic [THRESH_BITS-1:0] short_limit;
      logic [TICKS_BITS-1:0]  debounce_ticks;
      logic                   invert_output;
      logic [ALPHA_BITS-1:0]  filter_alpha;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/hsq_csr.sv */
// ----------------------------------------------------------------------------
// hsq_csr
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module hsq_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsq_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [hsq_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output hsq_pkg::cfg_type                    cfg
);
   import hsq_pkg::*;

   cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_threshold   <= LOW_THRESHOLD_RESET;
         cfg_ff.high_threshold  <= HIGH_THRESHOLD_RESET;
         cfg_ff.open_load_limit <= OPEN_LOAD_RESET;
         cfg_ff.short_limit     <= SHORT_RESET;
         cfg_ff.debounce_ticks  <= DEBOUNCE_RESET;
         cfg_ff.invert_output   <= INVERT_RESET;
         cfg_ff.filter_alpha    <= ALPHA_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_LOW_THRESHOLD:  cfg_ff.low_threshold   <= csr_data[THRESH_BITS-1:0];
            CSR_HIGH_THRESHOLD: cfg_ff.high_threshold  <= csr_data[THRESH_BITS-1:0];
            CSR_OPEN_LOAD:      cfg_ff.open_load_limit <= csr_data[THRESH_BITS-1:0];
            CSR_SHORT:          cfg_ff.short_limit     <= csr_data[THRESH_BITS-1:0];
            CSR_DEBOUNCE_TICKS: cfg_ff.debounce_ticks  <= csr_data[TICKS_BITS-1:0];
            CSR_INVERT:         cfg_ff.invert_output   <= csr_data[0];
            CSR_FILTER_ALPHA:   cfg_ff.filter_alpha    <= csr_data[ALPHA_BITS-1:0];
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/hsq_core.sv */
// ----------------------------------------------------------------------------
// hsq_core
// Sensor state: low-pass filter, window check, hysteresis debounce and
// event counter. Next state is presented every cycle, taken on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module hsq_core #(
   parameter int SAMPLE_BITS = hsq_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = hsq_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  logic [SAMPLE_BITS-1:0]            sample,
   input  hsq_pkg::cfg_type                  cfg,
   output logic [hsq_pkg::STATUS_BITS-1:0]   res_status,
   output logic                              res_event,
   output logic [hsq_pkg::EVENT_BITS-1:0]    res_count,
   output logic [SAMPLE_BITS-1:0]            res_filtered,
   output logic [COUNT_BITS-1:0]             res_down,
   output logic [COUNT_BITS-1:0]             res_up
);
   import hsq_pkg::*;

   localparam int CMP_BITS = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
   localparam int ACC_BITS = SAMPLE_BITS + ALPHA_BITS + 2;

   logic                   started_ff, started_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic [SAMPLE_BITS-1:0] filter_ff, filter_in;
   logic [COUNT_BITS-1:0]  fall_ff, fall_in;
   logic [COUNT_BITS-1:0]  rise_ff, rise_in;
   logic [EVENT_BITS-1:0]  events_ff, events_in;

   logic [ALPHA_BITS:0]    keep_weight;
   logic [ACC_BITS-1:0]    acc;
   logic [SAMPLE_BITS-1:0] filter_new;
   logic [CMP_BITS-1:0]    smp_ext, filt_ext;
   logic [COUNT_BITS-1:0]  reload;
   logic [STATUS_BITS-1:0] nx;
   logic                   was_on;
   logic                   event_hit;

   // q16 low-pass, two independent products
   assign keep_weight = (ALPHA_BITS+1)'(1 << ALPHA_BITS) - (ALPHA_BITS+1)'(cfg.filter_alpha);
   assign acc = ACC_BITS'(filter_ff) * ACC_BITS'(keep_weight)
              + ACC_BITS'(sample) * ACC_BITS'(cfg.filter_alpha);
   assign filter_new = acc[ALPHA_BITS +: SAMPLE_BITS];

   assign smp_ext  = CMP_BITS'(sample);
   assign filt_ext = CMP_BITS'(filter_new);
   assign reload   = cfg.debounce_ticks[COUNT_BITS-1:0];

   always_comb begin
      started_in = started_ff;
      status_in  = status_ff;
      filter_in  = filter_ff;
      fall_in    = fall_ff;
      rise_in    = rise_ff;
      events_in  = events_ff;
      event_hit  = 1'b0;
      nx         = status_ff;
      was_on     = 1'b0;
      if (!started_ff) begin
         started_in = 1'b1;
         filter_in  = sample;
         status_in  = '0;
         status_in[ST_ACTIVE] = (smp_ext > CMP_BITS'(cfg.high_threshold)) ^ cfg.invert_output;
         fall_in    = reload;
         rise_in    = reload;
      end else begin
         filter_in = filter_new;
         if (filt_ext > CMP_BITS'(cfg.open_load_limit) ||
             filt_ext < CMP_BITS'(cfg.short_limit)) begin
            status_in[ST_ERROR] = 1'b1;
            fall_in = reload;
            rise_in = reload;
         end else begin
            nx[ST_ERROR] = 1'b0;
            nx[ST_READY] = 1'b1;
            was_on = nx[ST_ACTIVE] ^ cfg.invert_output;
            if (was_on && smp_ext < CMP_BITS'(cfg.low_threshold)) begin
               if (fall_ff == '0) begin
                  nx[ST_ACTIVE] = cfg.invert_output;
               end else begin
                  fall_in = fall_ff - COUNT_BITS'(1);
               end
            end else if (!was_on && smp_ext > CMP_BITS'(cfg.high_threshold)) begin
               if (rise_ff == '0) begin
                  nx[ST_ACTIVE] = ~cfg.invert_output;
               end else begin
                  rise_in = rise_ff - COUNT_BITS'(1);
               end
            end else begin
               fall_in = reload;
               rise_in = reload;
            end
            if (nx[ST_ACTIVE] != status_ff[ST_ACTIVE]) begin
               event_hit = 1'b1;
               events_in = events_ff + EVENT_BITS'(1);
            end
            status_in = nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
         status_ff  <= '0;
         filter_ff  <= '0;
         fall_ff    <= '0;
         rise_ff    <= '0;
         events_ff  <= '0;
      end else if (advance) begin
         started_ff <= started_in;
         status_ff  <= status_in;
         filter_ff  <= filter_in;
         fall_ff    <= fall_in;
         rise_ff    <= rise_in;
         events_ff  <= events_in;
      end
   end

   assign res_status   = status_in;
   assign res_event    = event_hit;
   assign res_count    = events_in;
   assign res_filtered = filter_in;
   assign res_down     = fall_in;
   assign res_up       = rise_in;

endmodule

`default_nettype wire

/* rtl/hall_sensor_qualifier.sv */
// ----------------------------------------------------------------------------
// hall_sensor_qualifier
// Analog hall switch qualifier: low-pass filter, open/short window check,
// hysteresis with debounce counters and an event counter.
//
//   channel  dir  handshake          payload
//   req      in   valid / stall      sample
//   rsp      out  valid / stall      status_bits, event_res, event_count,
//                                    filtered_level, down_remaining, up_remaining
//   csr      in   valid / ready      index, data
//
// one beat per cycle in and out while rsp_stall is low; a sample is
// registered in the input register on entry, and its result is
// registered in the result register, with rsp_valid, once the output is open
// the filter multiply and debounce update are combinational
// reset clears the valid flags and the core state and loads the register
// defaults; csr_ready is always high
// a stalled result holds; one more sample is held in the input register
// before req_stall rises
// ----------------------------------------------------------------------------
`default_nettype none

module hall_sensor_qualifier #(
   parameter int SAMPLE_BITS = hsq_pkg::SAMPLE_BITS_DEFAULT,
   parameter int COUNT_BITS  = hsq_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [SAMPLE_BITS-1:0]             req_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [hsq_pkg::STATUS_BITS-1:0]    rsp_status_bits,
   output logic                               rsp_event_res,
   output logic [hsq_pkg::EVENT_BITS-1:0]     rsp_event_count,
   output logic [SAMPLE_BITS-1:0]             rsp_filtered_level,
   output logic [COUNT_BITS-1:0]              rsp_down_remaining,
   output logic [COUNT_BITS-1:0]              rsp_up_remaining,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hsq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [hsq_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import hsq_pkg::*;

   cfg_type cfg;

   logic                   s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic                   out_open;
   logic                   advance;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic                   rsp_event_ff;
   logic [EVENT_BITS-1:0]  rsp_count_ff;
   logic [SAMPLE_BITS-1:0] rsp_filtered_ff;
   logic [COUNT_BITS-1:0]  rsp_down_ff;
   logic [COUNT_BITS-1:0]  rsp_up_ff;

   logic [STATUS_BITS-1:0] res_status;
   logic                   res_event;
   logic [EVENT_BITS-1:0]  res_count;
   logic [SAMPLE_BITS-1:0] res_filtered;
   logic [COUNT_BITS-1:0]  res_down;
   logic [COUNT_BITS-1:0]  res_up;

   hsq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsq_core #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sample       (s1_sample_ff),
      .cfg          (cfg),
      .res_status   (res_status),
      .res_event    (res_event),
      .res_count    (res_count),
      .res_filtered (res_filtered),
      .res_down     (res_down),
      .res_up       (res_up)
   );

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_open;
   assign req_stall = s1_valid_ff && !out_open;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_sample_ff <= req_sample;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff   <= res_status;
         rsp_event_ff    <= res_event;
         rsp_count_ff    <= res_count;
         rsp_filtered_ff <= res_filtered;
         rsp_down_ff     <= res_down;
         rsp_up_ff       <= res_up;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status_bits    = rsp_status_ff;
   assign rsp_event_res      = rsp_event_ff;
   assign rsp_event_count    = rsp_count_ff;
   assign rsp_filtered_level = rsp_filtered_ff;
   assign rsp_down_remaining = rsp_down_ff;
   assign rsp_up_remaining   = rsp_up_ff;

   // error beat reloads both counters to the same value
   a_error_reload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff[ST_ERROR] |-> rsp_down_ff == rsp_up_ff)
      else $error("counters differ on an error beat");

   // no event on an error beat
   a_no_event_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff |-> !rsp_status_ff[ST_ERROR])
      else $error("event flagged with external error");

   // an accepted sample lands in the input register
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_valid_ff)
      else $error("accepted sample lost");

   // a waiting result with a held sample keeps the sample
   a_hold_s1: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |=> s1_valid_ff && $stable(s1_sample_ff))
      else $error("held sample changed under stall");

endmodule

`default_nettype wire

/* tb/hall_sensor_qualifier_test.sv */
// ----------------------------------------------------------------------------
// hall_sensor_qualifier_test
// Self-checking bench for the hall sensor qualifier. A per-sample predictor
// tracks the filter, window check, hysteresis debounce and event counter.
// Each accepted result beat is compared field by field with the oldest
// prediction. Directed cases come first, then event counter wrap, debounce
// sequences, back-pressure and noise under several register settings.
// Random sender gaps and receiver stalls run in the later tests.
// ----------------------------------------------------------------------------
`default_nettype none

module hall_sensor_qualifier_test;

   import hsq_pkg::*;

   localparam int SB             = SAMPLE_BITS_DEFAULT;
   localparam int CB             = COUNT_BITS_DEFAULT;
   localparam int HOLD_CYCLES    = 160;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int END_CYCLES     = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 3'd7;

   typedef enum {STALL_NONE, STALL_RANDOM, STALL_RUNS} stall_mode_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status_bits;
      logic                   event_res;
      logic [EVENT_BITS-1:0]  event_count;
      logic [SB-1:0]          filtered_level;
      logic [CB-1:0]          down_remaining;
      logic [CB-1:0]          up_remaining;
   } reading_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [SB-1:0]             req_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [STATUS_BITS-1:0]    rsp_status_bits;
   logic                      rsp_event_res;
   logic [EVENT_BITS-1:0]     rsp_event_count;
   logic [SB-1:0]             rsp_filtered_level;
   logic [CB-1:0]             rsp_down_remaining;
   logic [CB-1:0]             rsp_up_remaining;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // predictor state
   cfg_type                model_cfg;
   logic                   run_started;
   logic [STATUS_BITS-1:0] status_now;
   logic [SB-1:0]          filt_level;
   logic [CB-1:0]          fall_left;
   logic [CB-1:0]          rise_left;
   logic [EVENT_BITS-1:0]  seen_events;

   reading_type expected_readings[$];
   int          mismatch_count = 0;
   int          quiet_cycles = 0;

   stall_mode_type stall_mode = STALL_NONE;
   logic        hold_token = 1'b0;
   logic        hold_seen = 1'b0;
   int          hold_left = 0;
   int          run_left = 0;

   bit          gaps_on = 1'b0;
   int          burst_left = 0;

   hall_sensor_qualifier u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status_bits    (rsp_status_bits),
      .rsp_event_res      (rsp_event_res),
      .rsp_event_count    (rsp_event_count),
      .rsp_filtered_level (rsp_filtered_level),
      .rsp_down_remaining (rsp_down_remaining),
      .rsp_up_remaining   (rsp_up_remaining),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $realtime, what);
   endtask

   function automatic void predictor_reset();
      model_cfg.low_threshold   = LOW_THRESHOLD_RESET;
      model_cfg.high_threshold  = HIGH_THRESHOLD_RESET;
      model_cfg.open_load_limit = OPEN_LOAD_RESET;
      model_cfg.short_limit     = SHORT_RESET;
      model_cfg.debounce_ticks  = DEBOUNCE_RESET;
      model_cfg.invert_output   = INVERT_RESET;
      model_cfg.filter_alpha    = ALPHA_RESET;
      run_started = 1'b0;
      status_now  = '0;
      filt_level  = '0;
      fall_left   = '0;
      rise_left   = '0;
      seen_events = '0;
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_BITS-1:0] idx,
                                          input logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         CSR_LOW_THRESHOLD:  model_cfg.low_threshold   = data[THRESH_BITS-1:0];
         CSR_HIGH_THRESHOLD: model_cfg.high_threshold  = data[THRESH_BITS-1:0];
         CSR_OPEN_LOAD:      model_cfg.open_load_limit = data[THRESH_BITS-1:0];
         CSR_SHORT:          model_cfg.short_limit     = data[THRESH_BITS-1:0];
         CSR_DEBOUNCE_TICKS: model_cfg.debounce_ticks  = data[TICKS_BITS-1:0];
         CSR_INVERT:         model_cfg.invert_output   = data[0];
         CSR_FILTER_ALPHA:   model_cfg.filter_alpha    = data[ALPHA_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic void reload_counters();
      fall_left = model_cfg.debounce_ticks[CB-1:0];
      rise_left = model_cfg.debounce_ticks[CB-1:0];
   endfunction

   function automatic reading_type predict_reading(input logic [SB-1:0] smp);
      reading_type            r;
      logic [63:0]            acc;
      logic [STATUS_BITS-1:0] nx;
      logic                   was_on;
      r = '0;
      if (!run_started) begin
         run_started = 1'b1;
         filt_level  = smp;
         status_now  = '0;
         status_now[ST_ACTIVE] = (smp > model_cfg.high_threshold) ^ model_cfg.invert_output;
         reload_counters();
      end else begin
         acc = 64'(filt_level) * (64'd65536 - 64'(model_cfg.filter_alpha))
             + 64'(smp) * 64'(model_cfg.filter_alpha);
         filt_level = acc[SB+15:16];
         if (filt_level > model_cfg.open_load_limit || filt_level < model_cfg.short_limit) begin
            status_now[ST_ERROR] = 1'b1;
            reload_counters();
         end else begin
            nx = status_now;
            nx[ST_ERROR] = 1'b0;
            nx[ST_READY] = 1'b1;
            was_on = nx[ST_ACTIVE] ^ model_cfg.invert_output;
            if (was_on && smp < model_cfg.low_threshold) begin
               if (fall_left == '0) nx[ST_ACTIVE] = model_cfg.invert_output;
               else fall_left = fall_left - 1'b1;
            end else if (!was_on && smp > model_cfg.high_threshold) begin
               if (rise_left == '0) nx[ST_ACTIVE] = ~model_cfg.invert_output;
               else rise_left = rise_left - 1'b1;
            end else begin
               reload_counters();
            end
            if (nx[ST_ACTIVE] != status_now[ST_ACTIVE]) begin
               r.event_res = 1'b1;
               seen_events = seen_events + 1'b1;
            end
            status_now = nx;
         end
      end
      r.status_bits    = status_now;
      r.event_count    = seen_events;
      r.filtered_level = filt_level;
      r.down_remaining = fall_left;
      r.up_remaining   = rise_left;
      return r;
   endfunction

   // prediction, result checking and watchdog
   always @(posedge clock) begin : monitor
      reading_type got;
      reading_type want;
      if (reset) begin
         predictor_reset();
         expected_readings.delete();
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) apply_register(csr_index, csr_data);
         if (req_valid && !req_stall) expected_readings.push_back(predict_reading(req_sample));
         if (rsp_valid && !rsp_stall) begin
            got.status_bits    = rsp_status_bits;
            got.event_res      = rsp_event_res;
            got.event_count    = rsp_event_count;
            got.filtered_level = rsp_filtered_level;
            got.down_remaining = rsp_down_remaining;
            got.up_remaining   = rsp_up_remaining;
            if (expected_readings.size() == 0) begin
               report_mismatch("result beat with no prediction waiting");
            end else begin
               want = expected_readings.pop_front();
               if (got.status_bits !== want.status_bits)
                  report_mismatch($sformatf("status_bits got %0d want %0d",
                                            got.status_bits, want.status_bits));
               if (got.event_res !== want.event_res)
                  report_mismatch($sformatf("event_res got %0d want %0d",
                                            got.event_res, want.event_res));
               if (got.event_count !== want.event_count)
                  report_mismatch($sformatf("event_count got %0d want %0d",
                                            got.event_count, want.event_count));
               if (got.filtered_level !== want.filtered_level)
                  report_mismatch($sformatf("filtered_level got %0d want %0d",
                                            got.filtered_level, want.filtered_level));
               if (got.down_remaining !== want.down_remaining)
                  report_mismatch($sformatf("down_remaining got %0d want %0d",
                                            got.down_remaining, want.down_remaining));
               if (got.up_remaining !== want.up_remaining)
                  report_mismatch($sformatf("up_remaining got %0d want %0d",
                                            got.up_remaining, want.up_remaining));
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // receiver stall pattern and long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_seen <= 1'b0;
         hold_left <= 0;
         run_left  <= 0;
      end else if (hold_token != hold_seen) begin
         hold_seen <= hold_token;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_RUNS: begin
               if (run_left == 0) begin
                  rsp_stall <= ~rsp_stall;
                  run_left  <= rsp_stall ? $urandom_range(0, 12) : $urandom_range(0, 6);
               end else begin
                  run_left <= run_left - 1;
               end
            end
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   task automatic offer_sample(input logic [SB-1:0] s);
      req_valid  <= 1'b1;
      req_sample <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (gaps_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] low, input logic [15:0] high,
                                 input logic [15:0] open, input logic [15:0] short,
                                 input logic [15:0] ticks, input logic [15:0] inv,
                                 input logic [15:0] alpha);
      wait_drained();
      write_reg(CSR_LOW_THRESHOLD, low);
      write_reg(CSR_HIGH_THRESHOLD, high);
      write_reg(CSR_OPEN_LOAD, open);
      write_reg(CSR_SHORT, short);
      write_reg(CSR_DEBOUNCE_TICKS, ticks);
      write_reg(CSR_INVERT, inv);
      write_reg(CSR_FILTER_ALPHA, alpha);
   endtask

   function automatic logic [SB-1:0] qualifying_sample(input bit go_high);
      if (go_high && model_cfg.high_threshold < 10'd1023)
         return SB'($urandom_range(1023, int'(model_cfg.high_threshold) + 1));
      if (!go_high && model_cfg.low_threshold > 10'd0)
         return SB'($urandom_range(int'(model_cfg.low_threshold) - 1, 0));
      return SB'($urandom_range(0, 1023));
   endfunction

   function automatic logic [SB-1:0] between_sample();
      if (model_cfg.low_threshold <= model_cfg.high_threshold)
         return SB'($urandom_range(int'(model_cfg.high_threshold),
                                   int'(model_cfg.low_threshold)));
      return SB'($urandom_range(0, 1023));
   endfunction

   task automatic send_sequences(input int count);
      int n;
      int run;
      int roll;
      bit go_high;
      n = 0;
      while (n < count) begin
         go_high = $urandom_range(0, 1);
         run = $urandom_range(1, int'(model_cfg.debounce_ticks) + 4);
         for (int i = 0; i < run && n < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) offer_sample(SB'($urandom_range(0, 1023)));
            else if (roll < 14) offer_sample(between_sample());
            else offer_sample(qualifying_sample(go_high));
            n++;
         end
      end
   endtask

   // first sample after reset only initializes
   task automatic test_first_sample();
      stall_mode <= STALL_NONE;
      gaps_on = 1'b0;
      offer_sample(10'd1023);
   endtask

   task automatic test_directed_cases();
      // open-load error with the slow default filter
      offer_sample(10'd1023);
      offer_sample(10'd0);
      wait_drained();
      write_reg(CSR_FILTER_ALPHA, 16'hFFFF);
      // short-to-ground, open-load, then back inside the window
      offer_sample(10'd0);
      offer_sample(10'h2AA);
      offer_sample(10'h155);
      wait_drained();
      // masked invert write and immediate switching
      write_reg(CSR_INVERT, 16'hFFFE);
      write_reg(CSR_DEBOUNCE_TICKS, 16'd0);
      offer_sample(10'd500);
      offer_sample(10'd200);
      wait_drained();
      write_reg(CSR_DEBOUNCE_TICKS, 16'd1);
      write_reg(CSR_LOW_THRESHOLD, 16'hFD2C);
      write_reg(CSR_UNUSED, 16'hFFFF);
      offer_sample(10'd500);
      offer_sample(10'd500);
      offer_sample(10'd500);
      offer_sample(10'd500);
      offer_sample(10'd200);
      offer_sample(10'd200);
      offer_sample(10'd350);
      offer_sample(10'd200);
      offer_sample(10'd200);
      wait_drained();
      // zero alpha holds the filter
      write_reg(CSR_FILTER_ALPHA, 16'd0);
      offer_sample(10'd1023);
      offer_sample(10'd0);
   endtask

   task automatic test_event_wrap();
      write_settings(16'd300, 16'd400, 16'd1023, 16'd0, 16'd0,
                     16'($urandom_range(0, 65535)), 16'hFFFF);
      stall_mode <= STALL_RANDOM;
      gaps_on = 1'b1;
      for (int i = 0; i < 270; i++) offer_sample(qualifying_sample(i[0]));
   endtask

   task automatic test_debounce_sequences();
      int low;
      int high;
      for (int k = 0; k < 6; k++) begin
         low  = $urandom_range(50, 700);
         high = low + $urandom_range(0, 250);
         write_settings(16'(low), 16'(high), 16'($urandom_range(1023, high)),
                        16'($urandom_range(low / 2, 0)), 16'($urandom_range(0, 6)),
                        16'($urandom_range(0, 1)), 16'($urandom_range(65535, 8000)));
         stall_mode <= (k % 3 == 0) ? STALL_NONE : (k % 3 == 1) ? STALL_RANDOM : STALL_RUNS;
         gaps_on = (k % 2 == 1);
         send_sequences(60);
      end
   endtask

   task automatic test_hold_and_drain();
      write_settings(16'd250, 16'd450, 16'd900, 16'd20, 16'd2, 16'd1, 16'd40000);
      stall_mode <= STALL_NONE;
      gaps_on = 1'b0;
      hold_token <= ~hold_token;
      send_sequences(40);
      wait_drained();
      stall_mode <= STALL_RUNS;
      gaps_on = 1'b1;
      send_sequences(30);
   endtask

   task automatic test_noise();
      for (int k = 0; k < 4; k++) begin
         case (k)
            0: write_settings(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)),
                              16'($urandom_range(0, 65535)));
            1: write_settings(16'd0, 16'd1023, 16'd1023, 16'd0, 16'd3, 16'd1, 16'hFFFF);
            2: write_settings(16'd1023, 16'd0, 16'd1023, 16'd0, 16'd0, 16'd0, 16'd30000);
            default: write_settings(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                                    16'd0, 16'd1023, 16'hFFFF, 16'd1, 16'd1);
         endcase
         stall_mode <= (k % 2 == 0) ? STALL_RUNS : STALL_RANDOM;
         gaps_on = 1'b1;
         for (int i = 0; i < 50; i++) offer_sample(SB'($urandom_range(0, 1023)));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_first_sample();
      test_directed_cases();
      test_event_wrap();
      test_debounce_sequences();
      test_hold_and_drain();
      test_noise();
      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
